// ===== sv/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define FQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define FQS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fqs_pkg.sv =====
// Types and codes shared by the search queue modules.
package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP   = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;
  } fqs_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic                     found;
    logic [POS_W-1:0]         position;
    logic [LEN_W-1:0]         length;
    status_t                  status;
  } fqs_out_t;

  // Per-cell control: take the neighbor's word, or load the pushed word.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== sv/fqs_cell.sv =====
// One storage cell of the queue: holds a word, shifts toward the head, compares with the key.
module fqs_cell (
  input  logic                       clk,
  input  fqs_pkg::cell_ctrl_t        ctrl,
  input  logic [fqs_pkg::WORD_W-1:0] load_word,
  input  logic [fqs_pkg::WORD_W-1:0] next_word,
  input  logic [fqs_pkg::WORD_W-1:0] key,
  output logic [fqs_pkg::WORD_W-1:0] word,
  output logic                       match
);
  import fqs_pkg::*;

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word_r <= load_word;
    end else if (ctrl.shift) begin
      word_r <= next_word;
    end
  end

  assign word  = word_r;
  assign match = (word_r == key);

endmodule

// ===== sv/fqs_first_match.sv =====
// Finds the lowest set match flag and its index.
module fqs_first_match #(
  parameter int N = 16
) (
  input  logic [N-1:0]         match,
  output logic                 found,
  output logic [$clog2(N)-1:0] pos
);
  import fqs_pkg::*;

  localparam int IW = $clog2(N);

  logic [N-1:0] lowest;

  // Isolate the lowest set bit, then encode it.
  assign lowest = match & (~match + N'(1));
  assign found  = |match;

  always_comb begin
    pos = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

endmodule

// ===== sv/fifo_queue_with_search.sv =====
// Bounded FIFO of signed words with push, pop, drop, peek and search, built as a row of cells.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation per item: push, pop, drop head,
//   peek head or search; codes 5..7 are no-ops. out_valid/out_ready/out_data carry
//   exactly one result per item: head word, search flag and offset, length after
//   the operation, and a status of ok, empty or full.
//   Entries sit in a row of cells with the head in cell 0. Pop and drop shift every
//   cell one step toward the head; push loads the cell just past the last entry.
//   Search compares the key in every cell at once and a priority encoder picks the
//   match nearest the head.
//   Result: registered in the output register, valid in the cycle after the item is accepted.
//   Throughput: one item per cycle, set by the single output register; an item is
//   taken whenever that register is empty or being drained in the same cycle.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending result;
//   cell contents are not cleared and are never read before being written.
//   When the receiver stalls the result holds in the output register and in_ready
//   drops until it is taken.
`include "assert_macros.svh"

module fifo_queue_with_search (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fqs_pkg::fqs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fqs_pkg::fqs_out_t out_data
);
  import fqs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);

  // Queue occupancy and output register
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  fqs_out_t         out_r, out_nxt;

  // Cell row
  logic [WORD_W-1:0] words   [DEPTH];
  logic [WORD_W-1:0] nbr     [DEPTH];
  cell_ctrl_t        ctrl    [DEPTH];
  logic [DEPTH-1:0]  raw_match;
  logic [DEPTH-1:0]  live;
  logic [DEPTH-1:0]  hit;

  logic          accept;
  logic          do_push;
  logic          do_shift;
  logic          empty;
  logic          full;
  logic          srch_found;
  logic [IW-1:0] srch_pos;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));

  // Each cell takes its right-hand neighbor on a shift; the tail cell holds.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign nbr[i] = words[i];
    end else begin : g_mid
      assign nbr[i] = words[i+1];
    end

    assign live[i]       = (CNT_W'(i) < cnt_r);
    assign hit[i]        = raw_match[i] && live[i];
    assign ctrl[i].load  = do_push && (cnt_r == CNT_W'(i));
    assign ctrl[i].shift = do_shift;

    fqs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .load_word (in_data.value),
      .next_word (nbr[i]),
      .key       (in_data.value),
      .word      (words[i]),
      .match     (raw_match[i])
    );
  end

  fqs_first_match #(
    .N (DEPTH)
  ) u_first (
    .match (hit),
    .found (srch_found),
    .pos   (srch_pos)
  );

  // Operation decode and result assembly
  always_comb begin
    do_push          = 1'b0;
    do_shift         = 1'b0;
    cnt_nxt          = cnt_r;
    out_nxt.data     = '0;
    out_nxt.found    = 1'b0;
    out_nxt.position = '0;
    out_nxt.status   = ST_OK;
    case (in_data.op)
      OP_PUSH: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          do_push = accept;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_POP, OP_DROP, OP_PEEK: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          if (in_data.op != OP_DROP) begin
            out_nxt.data = words[0];
          end
          if (in_data.op != OP_PEEK) begin
            do_shift = accept;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
      end
      OP_SEARCH: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.found    = srch_found;
          out_nxt.position = POS_W'(srch_pos);
        end
      end
      default: begin
      end
    endcase
    out_nxt.length = LEN_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FQS_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "queue count exceeds depth")
  `FQS_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted item gave no result")
  `FQS_ASSERT_IMPL(a_found_ok, out_valid_r && out_r.found, out_r.status == ST_OK,
                   "search hit reported with bad status")
  `FQS_ASSERT_IMPL(a_empty_len, out_valid_r && out_r.status == ST_EMPTY,
                   out_r.length == '0, "empty status with nonzero length")
  `FQS_ASSERT_NEXT(a_push_count, accept && in_data.op == OP_PUSH && !full,
                   cnt_r == $past(cnt_r) + CNT_W'(1), "push did not grow the queue")

endmodule
